[rtl/core/itacc_pkg.sv]
// itacc_pkg: shared widths, saturation bounds and control structs for the
// inertia tensor accumulator. No dependencies.

package itacc_pkg;

   localparam int FIELD_W    = 16;
   localparam int NUM_ELEM   = 9;
   localparam int ACC_W      = 61;
   localparam int REQ_DATA_W = 7 * FIELD_W;
   localparam int RSP_DATA_W = ((NUM_ELEM * ACC_W + 7) / 8) * 8;

   localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

   // controls for the bit-serial multiply-accumulate lanes
   typedef struct packed {
      logic step;
      logic first;
      logic negate;
   } mac_ctrl_type;

   // controls for the saturating element accumulators
   typedef struct packed {
      logic add_en;
      logic clear;
   } acc_ctrl_type;

endpackage

[rtl/core/itacc_serial_mac.sv]
// itacc_serial_mac: one msb-first bit-serial multiplier lane, a parallel
// signed operand times one serial multiplier bit per cycle while ctrl.step is high. Uses itacc_pkg.

module itacc_serial_mac
   import itacc_pkg::*;
#(
   parameter int OP_W  = 33,
   parameter int ACC_W = 50
) (
   input  logic                    clock,
   input  mac_ctrl_type            ctrl,
   input  logic                    digit,
   input  logic signed [OP_W-1:0]  operand,
   output logic signed [ACC_W-1:0] product
);

   logic signed [ACC_W-1:0] acc_ff;
   logic signed [ACC_W-1:0] acc_in;
   logic signed [ACC_W-1:0] op_ext;
   logic signed [ACC_W-1:0] partial;

   assign op_ext = {{(ACC_W-OP_W){operand[OP_W-1]}}, operand};

   always_comb begin
      if (!digit) begin
         partial = '0;
      end else if (ctrl.negate) begin
         partial = -op_ext;
      end else begin
         partial = op_ext;
      end
      // first step restarts the product, later steps double and add
      if (ctrl.first) begin
         acc_in = partial;
      end else begin
         acc_in = (acc_ff <<< 1) + partial;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.step) begin
         acc_ff <= acc_in;
      end
   end

   assign product = acc_ff;

endmodule

[rtl/core/itacc_sat_acc.sv]
// itacc_sat_acc: one saturating 61-bit tensor element accumulator.
// Uses itacc_pkg for the width and the clamp bounds.

module itacc_sat_acc
   import itacc_pkg::*;
#(
   parameter int TERM_W = 50
) (
   input  logic                    clock,
   input  logic                    reset,
   input  acc_ctrl_type            ctrl,
   input  logic signed [TERM_W-1:0] term,
   output logic signed [ACC_W-1:0] sat_sum
);

   logic signed [ACC_W-1:0] acc_ff;
   logic signed [ACC_W-1:0] acc_in;
   logic signed [ACC_W:0]   sum_wide;

   // one guard bit is enough since the term is far below the bound
   assign sum_wide = {acc_ff[ACC_W-1], acc_ff}
                   + {{(ACC_W+1-TERM_W){term[TERM_W-1]}}, term};

   always_comb begin
      priority if (sum_wide[ACC_W] && !sum_wide[ACC_W-1]) begin
         sat_sum = ACC_MIN;
      end else if (!sum_wide[ACC_W] && sum_wide[ACC_W-1]) begin
         sat_sum = ACC_MAX;
      end else begin
         sat_sum = sum_wide[ACC_W-1:0];
      end
      acc_in = ctrl.clear ? '0 : sat_sum;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else if (ctrl.add_en) begin
         acc_ff <= acc_in;
      end
   end

endmodule

[rtl/core/inertia_tensor_accumulator.sv]
// inertia_tensor_accumulator: top level, sequencer, operand shift registers
// and result register. Uses itacc_pkg, itacc_serial_mac and itacc_sat_acc.
//
// Usage:
//   req_ channel carries one atom per transaction: mass and two position
//   vectors in req_tdata, req_tlast marks the final atom of a molecule.
//   rsp_ channel carries the nine tensor elements in rsp_tdata, one
//   transaction per molecule, after the atom marked last.
//   Each atom passes through the sequencer in order: it is taken, nine
//   bit-serial lanes form the position products over the POS_BITS
//   position bits, the diagonal sums are formed, the same lanes multiply
//   by the mass over the MASS_BITS mass bits, and the nine accumulators
//   take their saturating update.
//   rsp_tvalid is registered from the update of the atom marked last.
//   req_tready is high only while the sequencer waits for an atom.
//   The result sits in an output register; the next atom is taken while it
//   waits. Only the update of a last atom holds while the previous result
//   has not been taken.
//   Reset (synchronous, active high) clears all nine accumulators and drops
//   rsp_tvalid.

module inertia_tensor_accumulator
   import itacc_pkg::*;
#(
   parameter int POS_BITS  = 16,
   parameter int MASS_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // mass, first_x, first_y, first_z, second_x, second_y, second_z
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tlast,  // last_atom
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // tensor_xx, xy, xz, yx, yy, yz, zx, zy, zz, then zero fill
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   localparam int PROD_W  = 2 * POS_BITS;
   localparam int T_W     = PROD_W + 1;
   localparam int TERM_W  = MASS_BITS + PROD_W + 2;
   localparam int DIG_MAX = (POS_BITS > MASS_BITS) ? POS_BITS : MASS_BITS;
   localparam int CNT_W   = $clog2(DIG_MAX);

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_PROD  = 5'b00010,
      S_DIAG  = 5'b00100,
      S_MASS  = 5'b01000,
      S_ACCUM = 5'b10000
   } state_type;

   state_type                   state_ff, state_in;
   logic [CNT_W-1:0]            cnt_ff, cnt_in;
   logic                        last_ff;
   logic signed [POS_BITS-1:0]  p_ff [3];
   logic [POS_BITS-1:0]         q_sr_ff [3];
   logic [MASS_BITS-1:0]        m_sr_ff;
   logic signed [T_W-1:0]       t_ff [NUM_ELEM];
   logic signed [T_W-1:0]       t_in [NUM_ELEM];
   logic signed [T_W-1:0]       pp [NUM_ELEM];
   logic signed [TERM_W-1:0]    product [NUM_ELEM];
   logic signed [ACC_W-1:0]     sat_sum [NUM_ELEM];
   logic                        rsp_valid_ff;
   logic [RSP_DATA_W-1:0]       rsp_data_ff, rsp_data_in;
   logic                        out_blocked;
   logic                        accept;
   mac_ctrl_type                mac_ctrl;
   acc_ctrl_type                acc_ctrl;

   assign accept      = req_tvalid && req_tready;
   assign req_tready  = (state_ff == S_IDLE);
   assign out_blocked = last_ff && rsp_valid_ff && !rsp_tready;
   assign rsp_tvalid  = rsp_valid_ff;
   assign rsp_tdata   = rsp_data_ff;

   always_comb begin
      mac_ctrl = '0;
      acc_ctrl = '0;
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_PROD;
               cnt_in   = CNT_W'(POS_BITS - 1);
            end
         end
         S_PROD: begin
            mac_ctrl.step   = 1'b1;
            mac_ctrl.first  = (cnt_ff == CNT_W'(POS_BITS - 1));
            // sign bit of the serial operand comes first and counts negative
            mac_ctrl.negate = mac_ctrl.first;
            cnt_in          = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = S_DIAG;
            end
         end
         S_DIAG: begin
            state_in = S_MASS;
            cnt_in   = CNT_W'(MASS_BITS - 1);
         end
         S_MASS: begin
            mac_ctrl.step  = 1'b1;
            mac_ctrl.first = (cnt_ff == CNT_W'(MASS_BITS - 1));
            cnt_in         = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = S_ACCUM;
            end
         end
         S_ACCUM: begin
            if (!out_blocked) begin
               acc_ctrl.add_en = 1'b1;
               acc_ctrl.clear  = last_ff;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         if (acc_ctrl.add_en && last_ff) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // operand capture and serial shift registers
   always_ff @(posedge clock) begin
      if (accept) begin
         m_sr_ff <= req_tdata[MASS_BITS-1:0];
         last_ff <= req_tlast;
         for (int i = 0; i < 3; i++) begin
            p_ff[i]    <= req_tdata[FIELD_W*(1+i) +: POS_BITS];
            q_sr_ff[i] <= req_tdata[FIELD_W*(4+i) +: POS_BITS];
         end
      end else if (state_ff == S_PROD) begin
         for (int i = 0; i < 3; i++) begin
            q_sr_ff[i] <= {q_sr_ff[i][POS_BITS-2:0], 1'b0};
         end
      end else if (state_ff == S_MASS) begin
         m_sr_ff <= {m_sr_ff[MASS_BITS-2:0], 1'b0};
      end
   end

   // per-element factor: diagonal takes the sum of the other two diagonal products, off-diagonal the negated product
   always_comb begin
      for (int l = 0; l < NUM_ELEM; l++) begin
         pp[l]   = {product[l][PROD_W-1], product[l][PROD_W-1:0]};
         t_in[l] = -pp[l];
      end
      t_in[0] = pp[4] + pp[8];
      t_in[4] = pp[0] + pp[8];
      t_in[8] = pp[0] + pp[4];
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_DIAG) begin
         for (int l = 0; l < NUM_ELEM; l++) begin
            t_ff[l] <= t_in[l];
         end
      end
   end

   for (genvar l = 0; l < NUM_ELEM; l++) begin : g_lane
      localparam int ROW = l / 3;
      localparam int COL = l % 3;

      logic signed [T_W-1:0] operand;
      logic                  digit;

      assign operand = (state_ff == S_MASS) ? t_ff[l]
                     : {{(T_W-POS_BITS){p_ff[ROW][POS_BITS-1]}}, p_ff[ROW]};
      assign digit   = (state_ff == S_MASS) ? m_sr_ff[MASS_BITS-1]
                     : q_sr_ff[COL][POS_BITS-1];

      itacc_serial_mac #(
         .OP_W  (T_W),
         .ACC_W (TERM_W)
      ) u_mac (
         .clock   (clock),
         .ctrl    (mac_ctrl),
         .digit   (digit),
         .operand (operand),
         .product (product[l])
      );

      itacc_sat_acc #(
         .TERM_W (TERM_W)
      ) u_acc (
         .clock   (clock),
         .reset   (reset),
         .ctrl    (acc_ctrl),
         .term    (product[l]),
         .sat_sum (sat_sum[l])
      );
   end

   always_comb begin
      rsp_data_in = '0;
      for (int l = 0; l < NUM_ELEM; l++) begin
         rsp_data_in[l*ACC_W +: ACC_W] = sat_sum[l];
      end
   end

   always_ff @(posedge clock) begin
      if (acc_ctrl.add_en && last_ff) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

`ifndef SYNTHESIS
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_PROD))
      else $error("accepted atom did not start the product pass");

   a_blocked_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ACCUM) && out_blocked |=> (state_ff == S_ACCUM) && rsp_tvalid)
      else $error("last atom update did not wait for the pending result");

   a_last_emits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ACCUM) && last_ff && !out_blocked |=> rsp_tvalid)
      else $error("last atom did not produce a result");

   a_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("sequencer state lost its one-hot code");
`endif

endmodule
